// ===== hdl/tmvs_pkg.sv =====
package tmvs_pkg;

    localparam int WORD_BYTES   = 8;
    localparam int ADDRESS_BITS = 48;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic [CFG_ADDR_BITS-1:0] REG_VALUE_TYPE  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SCAN_MODE   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LOWER_BOUND = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_UPPER_BOUND = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LOW  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_HIGH = 3'd5;

    localparam logic [3:0] VT_INT8   = 4'd0;
    localparam logic [3:0] VT_INT16  = 4'd1;
    localparam logic [3:0] VT_INT32  = 4'd2;
    localparam logic [3:0] VT_INT64  = 4'd3;
    localparam logic [3:0] VT_UINT8  = 4'd4;
    localparam logic [3:0] VT_UINT16 = 4'd5;
    localparam logic [3:0] VT_UINT32 = 4'd6;
    localparam logic [3:0] VT_UINT64 = 4'd7;
    localparam logic [3:0] VT_FLOAT  = 4'd8;
    localparam logic [3:0] VT_DOUBLE = 4'd9;

    localparam logic [2:0] SM_EQUAL   = 3'd0;
    localparam logic [2:0] SM_GREATER = 3'd1;
    localparam logic [2:0] SM_LESS    = 3'd2;
    localparam logic [2:0] SM_BETWEEN = 3'd3;
    localparam logic [2:0] SM_ALL     = 3'd4;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] word_address;
        logic [63:0]             word_data;
        logic [3:0]              valid_bytes;
    } in_word_t;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] match_address;
        logic [63:0]             match_value;
        logic                    last_match;
    } out_word_t;

    typedef enum logic [1:0] {
        ORD_LT,
        ORD_EQ,
        ORD_GT,
        ORD_UN
    } order_t;

endpackage

// ===== hdl/typed_memory_value_scan_unit.sv =====
// A taken word passes the input register, then the match queue, then the result register before its first match shows.
// Throughput: one word per cycle while each word yields at most one match and out_stall is low;
//   a word with more matches stalls the input while the match queue drains one a cycle, unless out_stall holds it.
// Reset: rst_n asynchronous, active low; registers to their reset values
//   (window_high all ones), pipeline and queue empty.
module typed_memory_value_scan_unit
    import tmvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_word_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_word_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [63:0]              cfg_data
);

    localparam int NE = WORD_BYTES;

    logic [3:0]              vtype_reg;
    logic [2:0]              smode_reg;
    logic [63:0]             lower_reg, upper_reg;
    logic [ADDRESS_BITS-1:0] wlow_reg, whigh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtype_reg <= '0;
            smode_reg <= '0;
            lower_reg <= '0;
            upper_reg <= '0;
            wlow_reg  <= '0;
            whigh_reg <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VALUE_TYPE:  vtype_reg <= cfg_data[3:0];
                REG_SCAN_MODE:   smode_reg <= cfg_data[2:0];
                REG_LOWER_BOUND: lower_reg <= cfg_data;
                REG_UPPER_BOUND: upper_reg <= cfg_data;
                REG_WINDOW_LOW:  wlow_reg  <= cfg_data[ADDRESS_BITS-1:0];
                REG_WINDOW_HIGH: whigh_reg <= cfg_data[ADDRESS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic     iv_reg;
    in_word_t iw_reg;
    logic     in_take;

    // match queue: one word's candidates
    logic [NE-1:0]           pend_reg;
    logic [ADDRESS_BITS-1:0] qaddr_reg [NE];
    logic [63:0]             qval_reg  [NE];

    // result register
    logic      ov_reg;
    out_word_t ow_reg;

    function automatic logic [3:0] size_of(input logic [3:0] t);
        logic [3:0] s;
        s = 4'd0;
        unique case (t)
            VT_INT8, VT_UINT8:              s = 4'd1;
            VT_INT16, VT_UINT16:            s = 4'd2;
            VT_INT32, VT_UINT32, VT_FLOAT:  s = 4'd4;
            VT_INT64, VT_UINT64, VT_DOUBLE: s = 4'd8;
            default:                        s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] mask_of(input logic [3:0] s);
        logic [63:0] m;
        m = '0;
        unique case (s)
            4'd1:    m = 64'hFF;
            4'd2:    m = 64'hFFFF;
            4'd4:    m = 64'hFFFF_FFFF;
            4'd8:    m = '1;
            default: m = '0;
        endcase
        return m;
    endfunction

    // a and b already masked to the element size
    function automatic order_t order_of(input logic [63:0] a, input logic [63:0] b,
                                        input logic [3:0] t, input logic [3:0] s);
        logic [63:0] sg, ka, kb;
        logic        an, bn, az, bz, sa, sb;
        order_t      r;
        sg = '0; an = 1'b0; bn = 1'b0; az = 1'b0; bz = 1'b0;
        sa = 1'b0; sb = 1'b0;
        r = ORD_EQ;
        if (t == VT_FLOAT || t == VT_DOUBLE)
        begin
            if (t == VT_FLOAT)
            begin
                an = (a[30:23] == 8'hFF) && (a[22:0] != '0);
                bn = (b[30:23] == 8'hFF) && (b[22:0] != '0);
                az = a[30:0] == '0;
                bz = b[30:0] == '0;
                sa = a[31];
                sb = b[31];
                ka = {33'd0, a[30:0]};
                kb = {33'd0, b[30:0]};
            end
            else
            begin
                an = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
                bn = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
                az = a[62:0] == '0;
                bz = b[62:0] == '0;
                sa = a[63];
                sb = b[63];
                ka = {1'b0, a[62:0]};
                kb = {1'b0, b[62:0]};
            end
            if (an || bn)
                r = ORD_UN;
            else if (az && bz)
                r = ORD_EQ;
            else if (sa != sb)
                r = sa ? ORD_LT : ORD_GT;
            else if (ka == kb)
                r = ORD_EQ;
            else if ((ka < kb) != sa)
                r = ORD_LT;
            else
                r = ORD_GT;
        end
        else
        begin
            if (t <= VT_INT64)
                sg = ~(mask_of(s) >> 1) & mask_of(s);
            ka = a ^ sg;
            kb = b ^ sg;
            if (ka < kb)
                r = ORD_LT;
            else if (ka > kb)
                r = ORD_GT;
            else
                r = ORD_EQ;
        end
        return r;
    endfunction

    // stage 1: element selection and compare
    logic [3:0]              sz;
    logic [63:0]             msk;
    logic [NE-1:0]           hit;
    logic [ADDRESS_BITS-1:0] e_addr [NE];
    logic [63:0]             e_val  [NE];

    always_comb
    begin
        logic [3:0]              nv, off;
        logic [ADDRESS_BITS:0]   st;
        logic [ADDRESS_BITS-1:0] base;
        logic [ADDRESS_BITS:0]   endp;
        logic                    ok;
        order_t                  lo, hi;
        sz   = size_of(vtype_reg);
        msk  = mask_of(sz);
        nv   = (iw_reg.valid_bytes > 4'd8) ? 4'd8 : iw_reg.valid_bytes;
        base = iw_reg.word_address;
        for (int i = 0; i < NE; i++)
        begin
            off = 4'(i);
            st  = {1'b0, base} + (ADDRESS_BITS+1)'(off);
            e_addr[i] = st[ADDRESS_BITS-1:0];
            e_val[i]  = (iw_reg.word_data >> (8 * i)) & msk;
            endp = {1'b0, e_addr[i]} + (ADDRESS_BITS+1)'(sz);
            ok = (sz != 4'd0) && ((i % 8) == 0 || sz <= 4'(i) || 1'b1);
            ok = ok && ((off & (sz - 4'd1)) == 4'd0) && (5'(off) + 5'(sz) <= 5'(nv))
                 && !st[ADDRESS_BITS] && (e_addr[i] >= wlow_reg)
                 && (endp <= {1'b0, whigh_reg});
            lo = order_of(e_val[i], lower_reg & msk, vtype_reg, sz);
            hi = order_of(e_val[i], upper_reg & msk, vtype_reg, sz);
            unique case (smode_reg)
                SM_EQUAL:   ok = ok && (lo == ORD_EQ);
                SM_GREATER: ok = ok && (lo == ORD_GT);
                SM_LESS:    ok = ok && (lo == ORD_LT);
                SM_BETWEEN: ok = ok && (lo == ORD_EQ || lo == ORD_GT)
                                    && (hi == ORD_EQ || hi == ORD_LT);
                SM_ALL:     ok = ok;
                default:    ok = 1'b0;
            endcase
            hit[i] = iv_reg && ok;
        end
    end

    // queue drain
    logic          o_free;
    logic [NE-1:0] first_oh, rest;
    logic [2:0]    first_idx;
    logic          q_empty_next, load_q;

    assign o_free   = !ov_reg || !out_stall;
    assign first_oh = pend_reg & (~pend_reg + NE'(1));
    assign rest     = pend_reg & ~first_oh;

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < NE; i++)
            if (first_oh[i])
                first_idx = 3'(i);
    end

    assign q_empty_next = (pend_reg == '0) || (o_free && rest == '0);
    assign load_q       = q_empty_next;
    assign in_stall     = iv_reg && !load_q;
    assign in_take      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg   <= 1'b0;
            pend_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                iv_reg <= in_valid;
            if (o_free)
                ov_reg <= pend_reg != '0;
            if (load_q)
                pend_reg <= hit;
            else if (o_free)
                pend_reg <= rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            iw_reg <= in_data;
        if (load_q)
        begin
            for (int i = 0; i < NE; i++)
            begin
                qaddr_reg[i] <= e_addr[i];
                qval_reg[i]  <= e_val[i];
            end
        end
        if (o_free && pend_reg != '0)
        begin
            ow_reg.match_address <= qaddr_reg[first_idx];
            ow_reg.match_value   <= qval_reg[first_idx];
            ow_reg.last_match    <= rest == '0;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = ow_reg;

endmodule

// ===== hdl/tmvs_checker.sv =====
module tmvs_checker
    import tmvs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data,
    input logic      cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

    a_no_out_after_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result after reset");

    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && !in_stall |=> !in_stall)
        else $error("input stalled with no word held");

endmodule

bind typed_memory_value_scan_unit tmvs_checker u_tmvs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_ready(cfg_ready)
);
